// File: hw/rtl/rcb_pkg.sv
package rcb_pkg;

  localparam int PIXEL_W  = 16;
  localparam int AMOUNT_W = 8;
  localparam int RED_W    = 5;
  localparam int GREEN_W  = 6;
  localparam int BLUE_W   = 5;

  localparam int BLUE_LSB  = 0;
  localparam int GREEN_LSB = BLUE_LSB + BLUE_W;
  localparam int RED_LSB   = GREEN_LSB + GREEN_W;

  localparam logic [AMOUNT_W-1:0] FADE_FULL  = 8'd255;
  localparam logic [AMOUNT_W-1:0] FADE_ROUND = 8'd127;

  typedef logic [PIXEL_W-1:0]  pixel_t;
  typedef logic [AMOUNT_W-1:0] amount_t;

endpackage

// File: hw/rtl/rcb_in_if.sv
interface rcb_in_if
  import rcb_pkg::*;
;
  logic    valid;
  logic    ready;
  pixel_t  source_pixel;
  pixel_t  target_pixel;
  amount_t fade_amount;
  logic    last_pixel;

  modport source (
    output valid, source_pixel, target_pixel, fade_amount, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, source_pixel, target_pixel, fade_amount, last_pixel,
    output ready
  );
endinterface

// File: hw/rtl/rcb_out_if.sv
interface rcb_out_if
  import rcb_pkg::*;
;
  logic   valid;
  logic   ready;
  pixel_t blended_pixel;
  logic   last_out;

  modport source (
    output valid, blended_pixel, last_out,
    input  ready
  );

  modport sink (
    input  valid, blended_pixel, last_out,
    output ready
  );
endinterface

// File: hw/rtl/rcb_channel_mix.sv
module rcb_channel_mix
  import rcb_pkg::*;
#(
  parameter int CHAN_W = GREEN_W
) (
  input  logic [CHAN_W-1:0] src,
  input  logic [CHAN_W-1:0] tgt,
  input  amount_t           amount,
  output logic [CHAN_W-1:0] mix
);

  localparam int SUM_W = CHAN_W + AMOUNT_W;

  amount_t              inv_amount;
  logic [SUM_W-1:0]     weighted;
  logic [SUM_W:0]       corrected;
  logic [SUM_W-8:0]     quotient;

  // Division by 255 is done as (x + 1 + x/256) / 256, exact over this range.
  always_comb begin
    inv_amount = FADE_FULL - amount;
    weighted   = SUM_W'(src) * SUM_W'(inv_amount) + SUM_W'(tgt) * SUM_W'(amount)
               + SUM_W'(FADE_ROUND);
    corrected  = (SUM_W+1)'(weighted) + (SUM_W+1)'(1)
               + (SUM_W+1)'(weighted >> 8);
    quotient   = corrected[SUM_W:8];
    mix        = quotient[CHAN_W-1:0];
  end

endmodule

// File: hw/rtl/rgb565_crossfade_blend.sv
// Crossfades a stream of RGB565 pixel pairs: each channel becomes
// (source*(255-amount) + target*amount + 127) / 255, rounded to nearest, and
// the last-pixel mark of each transaction is passed on with its result. The
// block is a two-stage pipeline (an input register, then the channel mixers
// feeding a result register); a taken transaction moves through both registers
// in turn, and one pixel is accepted every clock while the output keeps up.
// The input stays ready while a finished result waits, as long as the input
// register is empty.
module rgb565_crossfade_blend
  import rcb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  rcb_in_if.sink           pixel_in,
  rcb_out_if.source        pixel_out
);

  logic    s1_valid;
  pixel_t  s1_src;
  pixel_t  s1_tgt;
  amount_t s1_amt;
  logic    s1_last;

  logic    out_valid;
  pixel_t  out_pixel;
  logic    out_last;

  logic    out_free;
  logic    s1_free;
  pixel_t  blended_next;

  logic [RED_W-1:0]   red_mix;
  logic [GREEN_W-1:0] green_mix;
  logic [BLUE_W-1:0]  blue_mix;

  assign out_free = !out_valid || pixel_out.ready;
  assign s1_free  = !s1_valid || out_free;

  assign pixel_in.ready          = s1_free;
  assign pixel_out.valid         = out_valid;
  assign pixel_out.blended_pixel = out_pixel;
  assign pixel_out.last_out      = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && pixel_in.valid) begin
      s1_src  <= pixel_in.source_pixel;
      s1_tgt  <= pixel_in.target_pixel;
      s1_amt  <= pixel_in.fade_amount;
      s1_last <= pixel_in.last_pixel;
    end
  end

  rcb_channel_mix #(.CHAN_W(RED_W)) u_red (
    .src    (s1_src[RED_LSB +: RED_W]),
    .tgt    (s1_tgt[RED_LSB +: RED_W]),
    .amount (s1_amt),
    .mix    (red_mix)
  );

  rcb_channel_mix #(.CHAN_W(GREEN_W)) u_green (
    .src    (s1_src[GREEN_LSB +: GREEN_W]),
    .tgt    (s1_tgt[GREEN_LSB +: GREEN_W]),
    .amount (s1_amt),
    .mix    (green_mix)
  );

  rcb_channel_mix #(.CHAN_W(BLUE_W)) u_blue (
    .src    (s1_src[BLUE_LSB +: BLUE_W]),
    .tgt    (s1_tgt[BLUE_LSB +: BLUE_W]),
    .amount (s1_amt),
    .mix    (blue_mix)
  );

  assign blended_next = {red_mix, green_mix, blue_mix};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_pixel <= blended_next;
      out_last  <= s1_last;
    end
  end

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    pixel_in.valid && pixel_in.ready |=> s1_valid)
    else $error("accepted transaction did not reach the input register");

  a_s1_moves_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_free |=> out_valid)
    else $error("input register advanced without filling the result register");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> pixel_in.ready)
    else $error("input stalled although the result register is empty");

  a_zero_amount_source: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_amt == '0 |-> blended_next == s1_src)
    else $error("zero fade amount did not return the source pixel");

  a_full_amount_target: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_amt == FADE_FULL |-> blended_next == s1_tgt)
    else $error("full fade amount did not return the target pixel");

endmodule
